/* src/lwma_pkg.sv */
// shared types and constants for the linear weighted moving average
`timescale 1ns / 1ps
`default_nettype none

package lwma_pkg;

  // payload and state widths
  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned PERIOD_W   = 6;
  localparam int unsigned PLAIN_W    = 38;
  localparam int unsigned WSUM_W     = 44;
  localparam int unsigned FILL_W     = 7;
  localparam int unsigned HIST_DEPTH = 64;
  localparam int unsigned PTR_W      = $clog2(HIST_DEPTH);
  localparam int unsigned PROD_W     = FILL_W + PRICE_W;

  // divider widths: numerator carries the rounding half, denominator up to 2080
  localparam int unsigned NUM_W  = WSUM_W + 1;
  localparam int unsigned DEN_W  = 12;
  localparam int unsigned CNT_W  = $clog2(NUM_W + 1);

  // register port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);

  // register index decoded from the word address
  typedef enum logic [0:0] {
    REG_PERIOD = 1'b0,
    REG_NONE   = 1'b1
  } reg_idx_e;

  // request to the divider
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // response from the divider
  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

/* src/lwma_if.sv */
// valid/ready channel interfaces for price samples and averages
`timescale 1ns / 1ps
`default_nettype none

interface lwma_in_if import lwma_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink   (input valid, input price, output ready);
endinterface

interface lwma_out_if import lwma_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] average;
  logic               valid_res;

  modport source (output valid, output average, output valid_res, input ready);
  modport sink   (input valid, input average, input valid_res, output ready);
endinterface

`default_nettype wire

/* src/lwma_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module lwma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/lwma_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module lwma_div import lwma_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output      div_rsp_t rsp_o
);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             qbit;
  logic [DEN_W:0]   diff;

  // shift in the next numerator bit and try to subtract
  always_comb begin
    trial = {rem_q, quot_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
  end

  // control: busy flag, bit counter, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder and numerator/quotient shift register
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      den_q  <= req_i.den;
      quot_q <= req_i.num;
    end else if (busy_q) begin
      rem_q  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot_q <= {quot_q[NUM_W-2:0], qbit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

/* src/linear_weighted_moving_average.sv */
// linear weighted moving average: sequencer, running sums and register port
// full window: the sample transfer is followed by multiply, sum update, divider launch,
// divide, quotient capture and output load; while filling the divide is skipped (zero result)
// input ready again the cycle after the output load, so a new sample waits for the last
// result, and also while an earlier result still waits in the output register
// reset (async, active low) clears sums, fill count, pointer, sets period 14; ram not cleared
`timescale 1ns / 1ps
`default_nettype none

module linear_weighted_moving_average import lwma_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  lwma_in_if.sink                in_i,
  lwma_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_SETUP,
    S_DIV,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [PERIOD_W-1:0] period_q;
  logic [PLAIN_W-1:0]  plain_q;
  logic [WSUM_W-1:0]   wsum_q;
  logic [FILL_W-1:0]   fill_q;
  logic [PTR_W-1:0]    wptr_q;
  logic [PRICE_W-1:0]  x_q;
  logic [PROD_W-1:0]   prod_q;
  logic [FILL_W-1:0]   weight_q;
  logic                full_q;
  logic [PRICE_W-1:0]  res_avg_q;
  logic                res_vres_q;
  logic                out_valid_q;
  logic [PRICE_W-1:0]  out_avg_q;
  logic                out_vres_q;

  logic [FILL_W-1:0]   win_len;
  logic                full_now;
  logic [FILL_W-1:0]   weight;
  logic                in_xfer;
  logic                out_load;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;
  logic [2*FILL_W-1:0] den_full;
  logic [DEN_W-1:0]    den;
  logic [PRICE_W-1:0]  old_sample;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // window length and the weight of the incoming sample
  always_comb begin
    win_len  = FILL_W'(period_q) + FILL_W'(1);
    full_now = (fill_q >= win_len);
    weight   = full_now ? win_len : fill_q + FILL_W'(1);
    den_full = (2*FILL_W)'(win_len) * (2*FILL_W)'(win_len + FILL_W'(1));
    den      = den_full[DEN_W:1];
  end

  // register port decode
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1]);
  assign cfg_wr  = psel && penable && pwrite && (cfg_idx == REG_PERIOD);
  assign pready  = 1'b1;
  assign prdata  = (cfg_idx == REG_PERIOD) ? APB_DW'(period_q) : '0;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  // finished result moves into a free or draining output register
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // divider launch with the rounding half added to the weighted sum
  always_comb begin
    div_req.start = (state_q == S_SETUP);
    div_req.num   = NUM_W'(wsum_q) + NUM_W'(den[DEN_W-1:1]);
    div_req.den   = den;
  end

  // sample history ring, oldest entry read at transfer in
  lwma_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (state_q == S_UPDATE),
    .waddr_i (wptr_q),
    .wdata_i (x_q),
    .re_i    (in_xfer),
    .raddr_i (wptr_q - win_len[PTR_W-1:0]),
    .rdata_o (old_sample)
  );

  lwma_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer with running sums and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= PERIOD_RESET;
      plain_q     <= '0;
      wsum_q      <= '0;
      fill_q      <= '0;
      wptr_q      <= '0;
      x_q         <= '0;
      prod_q      <= '0;
      weight_q    <= '0;
      full_q      <= 1'b0;
      res_avg_q   <= '0;
      res_vres_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_avg_q   <= '0;
      out_vres_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        period_q <= pwdata[PERIOD_W-1:0];
        plain_q  <= '0;
        wsum_q   <= '0;
        fill_q   <= '0;
        wptr_q   <= '0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            x_q     <= in_i.price;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          prod_q   <= PROD_W'(weight) * PROD_W'(x_q);
          weight_q <= weight;
          full_q   <= full_now;
          state_q  <= S_UPDATE;
        end
        S_UPDATE: begin
          if (full_q) begin
            wsum_q  <= wsum_q - WSUM_W'(plain_q) + WSUM_W'(prod_q);
            plain_q <= plain_q - PLAIN_W'(old_sample) + PLAIN_W'(x_q);
          end else begin
            wsum_q  <= wsum_q + WSUM_W'(prod_q);
            plain_q <= plain_q + PLAIN_W'(x_q);
          end
          fill_q <= weight_q;
          wptr_q <= wptr_q + PTR_W'(1);
          if (weight_q == win_len) begin
            state_q <= S_SETUP;
          end else begin
            res_avg_q  <= '0;
            res_vres_q <= 1'b0;
            state_q    <= S_DONE;
          end
        end
        S_SETUP: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_avg_q  <= (div_rsp.quot[NUM_W-1:PRICE_W] != '0) ? '1
                                                                : div_rsp.quot[PRICE_W-1:0];
            res_vres_q <= 1'b1;
            state_q    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_avg_q  <= res_avg_q;
            out_vres_q <= res_vres_q;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.average   = out_avg_q;
  assign out_o.valid_res = out_vres_q;

  // fill count never runs past the window
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win_len)
    else $error("fill count exceeds window length");

  // a result without a full window carries a zero average
  a_zero_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.valid_res |-> out_o.average == '0)
    else $error("average nonzero while window not full");

  // after a sample transfer the block stays busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_i.ready)
    else $error("input ready right after a transfer");

  // the divider only finishes while the sequencer waits on it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider done outside of divide state");

endmodule

`default_nettype wire

/* test/tb_top.sv */
// self-checking testbench for the linear weighted moving average block
`timescale 1ns / 1ps

module tb_top;
  import lwma_pkg::*;

  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_ITEMS    = 68;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned END_CYCLES     = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [PRICE_W-1:0] average;
    logic               valid_res;
  } avg_result_t;

  // running-sum predictor and queue of expected averages
  class lwma_scoreboard;
    logic [PRICE_W-1:0]  history [HIST_DEPTH];
    logic [PLAIN_W-1:0]  plain_sum;
    logic [WSUM_W-1:0]   weighted_sum;
    int unsigned         fill;
    int unsigned         wr_ptr;
    logic [PERIOD_W-1:0] period;
    avg_result_t         pending_q[$];
    int unsigned         errors;

    function new();
      period = PERIOD_RESET;
      errors = 0;
      clear_window();
    endfunction

    function void clear_window();
      plain_sum    = '0;
      weighted_sum = '0;
      fill         = 0;
      wr_ptr       = 0;
    endfunction

    // any write to the period register restarts the window
    function void write_period(logic [PERIOD_W-1:0] value);
      period = value;
      clear_window();
    endfunction

    function void note_price(logic [PRICE_W-1:0] price);
      int unsigned        win;
      int unsigned        slot;
      logic [DEN_W-1:0]   den;
      logic [NUM_W-1:0]   num;
      logic [NUM_W-1:0]   quot;
      avg_result_t        res;
      win = int'(period) + 1;
      if (fill >= win) begin
        // full window: oldest sample leaves, every weight drops by one
        slot         = (wr_ptr + HIST_DEPTH - win) % HIST_DEPTH;
        weighted_sum = weighted_sum - WSUM_W'(plain_sum) + WSUM_W'(win) * WSUM_W'(price);
        plain_sum    = plain_sum - PLAIN_W'(history[slot]) + PLAIN_W'(price);
        fill         = win;
      end else begin
        weighted_sum = weighted_sum + WSUM_W'(fill + 1) * WSUM_W'(price);
        plain_sum    = plain_sum + PLAIN_W'(price);
        fill++;
      end
      history[wr_ptr] = price;
      wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
      res = '0;
      if (fill >= win) begin
        // divide by the weight total, round half up, saturate to the price width
        den  = DEN_W'(win * (win + 1) / 2);
        num  = NUM_W'(weighted_sum) + NUM_W'(den / 2);
        quot = num / NUM_W'(den);
        res.average   = (quot > NUM_W'({PRICE_W{1'b1}})) ? '1 : quot[PRICE_W-1:0];
        res.valid_res = 1'b1;
      end
      pending_q.push_back(res);
    endfunction

    function void check_average(logic [PRICE_W-1:0] average, logic valid_res);
      avg_result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing pending: average %h valid_res %b",
                 $time, average, valid_res);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (average !== want.average) begin
        $display("%0t: average expected %h actual %h", $time, want.average, average);
        errors++;
      end
      if (valid_res !== want.valid_res) begin
        $display("%0t: valid_res expected %b actual %b", $time, want.valid_res, valid_res);
        errors++;
      end
    endfunction

    function void check_period(logic [APB_DW-1:0] rdata);
      if (rdata !== APB_DW'(period)) begin
        $display("%0t: period readback expected %h actual %h",
                 $time, APB_DW'(period), rdata);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lwma_in_if  in_if ();
  lwma_out_if out_if ();

  lwma_scoreboard sb = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  linear_weighted_moving_average DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_price(in_if.price);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_average(out_if.average, out_if.valid_res);
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("[linear_weighted_moving_average] ERROR");
      $finish;
    end
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // offer one price, with a random idle gap ahead of it
  task automatic offer_price(input logic [PRICE_W-1:0] price);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.price <= price;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // stop offering and wait until every expected average has come back
  task automatic wait_for_averages();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write a register, then read the period back
  task automatic program_register(input reg_idx_e idx, input logic [PERIOD_W-1:0] value);
    logic [APB_DW-1:0] wdata;
    wdata = $urandom;
    wdata[PERIOD_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_PERIOD) begin
      sb.write_period(value);
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_PERIOD, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.check_period(prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [PERIOD_W-1:0] next_period;
    logic [PRICE_W-1:0]  price;
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.price <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset period: full-scale window, then a zero entering it
    repeat (15) offer_price('1);
    offer_price('0);

    // single-sample window follows the price
    wait_for_averages();
    program_register(REG_PERIOD, '0);
    offer_price('0);
    offer_price('1);
    offer_price(PRICE_W'(1));

    // rewriting the same period still restarts the window
    wait_for_averages();
    program_register(REG_PERIOD, PERIOD_W'(1));
    offer_price('1);
    offer_price('1);
    wait_for_averages();
    program_register(REG_PERIOD, PERIOD_W'(1));
    offer_price(PRICE_W'(9));

    // write to an unmapped address leaves period and window alone
    wait_for_averages();
    program_register(REG_NONE, PERIOD_W'(5));
    offer_price(PRICE_W'(3));

    // random phases over several periods and idle patterns
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_for_averages();
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
      endcase
      case (ph)
        0, 5:    next_period = PERIOD_W'(63);
        1:       next_period = PERIOD_W'(1);
        2:       next_period = '0;
        3:       next_period = PERIOD_W'(7);
        6:       next_period = PERIOD_W'(2);
        8:       next_period = PERIOD_W'(31);
        default: next_period = PERIOD_W'($urandom_range(63));
      endcase
      program_register(REG_PERIOD, next_period);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        // back pressure: result side holds off, later the sender drains
        if (ph == 4 && i == 20) hold_request = 1'b1;
        if (ph == 4 && i == 45) wait_for_averages();
        case ($urandom_range(7))
          0:       price = '0;
          1:       price = '1;
          2:       price = PRICE_W'($urandom_range(1023));
          3:       price = ~PRICE_W'($urandom_range(1023));
          default: price = $urandom;
        endcase
        offer_price(price);
      end
    end

    // drain and let any stray result show up
    wait_for_averages();
    repeat (END_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[linear_weighted_moving_average] OK");
    end else begin
      $display("[linear_weighted_moving_average] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/lwma_pkg.sv
src/lwma_if.sv
src/lwma_ram.sv
src/lwma_div.sv
src/linear_weighted_moving_average.sv
test/tb_top.sv
